/* hdl/tbm_pkg.sv */
// Shared types and constants of the burst median tachometer.
`timescale 1ns / 1ps

package tbm_pkg;

    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int LOCKOUT_W  = 16;
    localparam int STALL_W    = 24;
    localparam int WINDOW_W   = 24;
    localparam int PPR_W      = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 4;
    localparam int PROD_W     = TIME_W + PPR_W;

    localparam int BURST_LEN_DEF = 9;

    // Speed numerator: microseconds per minute.
    localparam int unsigned RPM_NUM = 60_000_000;
    localparam int NUM_W = $clog2(RPM_NUM + 1);
    localparam int DCNT_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] NUM_BITS = NUM_W'(RPM_NUM);
    // Divisors at or below this give a quotient that no longer fits in SPEED_W bits.
    localparam int unsigned SAT_LIMIT = RPM_NUM / (1 << SPEED_W);

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = LOCKOUT_W'(1500);
    localparam logic [STALL_W-1:0]   STALL_RST   = STALL_W'(500000);
    localparam logic [WINDOW_W-1:0]  WINDOW_RST  = WINDOW_W'(200000);
    localparam logic [PPR_W-1:0]     PPR_RST     = PPR_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCKOUT = 2'd0,
        CFG_STALL   = 2'd1,
        CFG_WINDOW  = 2'd2,
        CFG_PPR     = 2'd3
    } t_cfg_idx;

    // What one sorter cell hands to its right-hand neighbour.
    typedef struct packed {
        logic               gt;
        logic [SPEED_W-1:0] value;
    } t_link;

endpackage

/* hdl/tachometer_burst_median_top.sv */
// Burst median tachometer: one request per microsecond tick, one report per finished burst.
// A tick without an accepted pulse is evaluated and, when it ends a burst, goes on to the median pick.
// A tick with an accepted pulse also runs the 26-step serial speed divider before the sample is
// inserted; a speed that saturates or falls to zero skips the divider steps.
// The report is held in an output register; a new tick is taken while it waits.
// Synchronous active-low reset clears time, burst state and configuration to defaults.
`timescale 1ns / 1ps

module tachometer_burst_median_top
    import tbm_pkg::*;
#(
    parameter int BURST_LEN = BURST_LEN_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_pulse,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SPEED_W-1:0]    o_rpm,
    output logic                  o_stalled,
    output logic [COUNT_W-1:0]    o_sample_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(BURST_LEN + 1);
    localparam int IDX_W = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
    localparam logic [CNT_W-1:0] N_C = CNT_W'(BURST_LEN);
    localparam logic [CNT_W-1:0] M_C = CNT_W'(BURST_LEN / 2);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_INS  = 5'b01000,
        S_PICK = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;

    logic [LOCKOUT_W-1:0]  r_lockout;
    logic [STALL_W-1:0]    r_stall_us;
    logic [WINDOW_W-1:0]   r_window;
    logic [PPR_W-1:0]      r_ppr;

    logic [TIME_W-1:0]     r_time;
    logic [TIME_W-1:0]     r_last;
    logic [TIME_W-1:0]     r_burst;
    logic [TIME_W-1:0]     r_gap;
    logic [TIME_W-1:0]     r_interval;
    logic [CNT_W-1:0]      r_fill;
    logic                  r_stall_rep;
    logic                  r_ins;
    logic                  r_emit;
    logic                  r_out_stalled;
    logic [COUNT_W-1:0]    r_out_cnt;
    logic                  r_pick_zero;
    logic [IDX_W-1:0]      r_pick_idx;

    logic                  r_valid;
    logic [SPEED_W-1:0]    r_rpm;
    logic                  r_stalled;
    logic [COUNT_W-1:0]    r_count;

    logic                  accept;
    logic                  acc_pulse;
    logic [TIME_W-1:0]     since_pulse;
    logic [TIME_W-1:0]     since_burst;
    logic                  stall;
    logic                  elapsed;
    logic [CNT_W-1:0]      fill_n;
    logic                  full;
    logic                  stall_emit;
    logic                  tmo_emit;
    logic                  emit;
    logic [CNT_W:0]        zsum;
    logic [CNT_W:0]        zdiff;
    logic [CNT_W-1:0]      half;
    logic [CNT_W+COUNT_W-1:0] fill_ext;
    logic                  out_free;

    logic                  div_start;
    logic                  div_done;
    logic [SPEED_W-1:0]    div_speed;

    t_link                 links [BURST_LEN+1];
    logic [BURST_LEN-1:0]  occ;
    logic [BURST_LEN-1:0]  order_ok;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout  <= LOCKOUT_RST;
            r_stall_us <= STALL_RST;
            r_window   <= WINDOW_RST;
            r_ppr      <= PPR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOCKOUT: r_lockout  <= i_cfg_data[LOCKOUT_W-1:0];
                CFG_STALL:   r_stall_us <= i_cfg_data[STALL_W-1:0];
                CFG_WINDOW:  r_window   <= i_cfg_data[WINDOW_W-1:0];
                CFG_PPR:     r_ppr      <= i_cfg_data[PPR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    // r_gap already holds the interval that a pulse on the next tick would measure.
    assign acc_pulse = i_pulse && (r_gap > TIME_W'(r_lockout));

    assign since_pulse = r_time - r_last;
    assign since_burst = r_time - r_burst;
    assign stall       = since_pulse > TIME_W'(r_stall_us);
    assign elapsed     = since_burst >= TIME_W'(r_window);
    assign fill_n      = r_fill + CNT_W'(r_ins);
    assign full        = (fill_n >= N_C);
    assign stall_emit  = stall && (!r_stall_rep || elapsed);
    assign tmo_emit    = elapsed && !stall;
    assign emit        = full || stall_emit || tmo_emit;

    // With zero fill the low BURST_LEN - n sorted places are zero.
    assign zsum     = {1'b0, fill_n} + {1'b0, M_C};
    assign zdiff    = zsum - {1'b0, N_C};
    assign half     = fill_n >> 1;
    assign fill_ext = {{COUNT_W{1'b0}}, fill_n};

    assign out_free  = !r_valid || i_ready;
    assign div_start = (r_state == S_EVAL) && r_ins;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EVAL;
            S_EVAL: begin
                if (r_ins) begin
                    n_state = S_DIV;
                end else if (emit) begin
                    n_state = S_PICK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV:  if (div_done) n_state = S_INS;
            S_INS:  n_state = r_emit ? S_PICK : S_IDLE;
            S_PICK: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_last      <= '0;
            r_burst     <= '0;
            r_gap       <= TIME_W'(1);
            r_fill      <= '0;
            r_stall_rep <= 1'b0;
            r_ins       <= 1'b0;
            r_emit      <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PICK && out_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_time <= r_time + TIME_W'(1);
                        r_ins  <= acc_pulse && (r_fill < N_C);
                        if (acc_pulse) begin
                            r_last      <= r_time + TIME_W'(1);
                            r_stall_rep <= 1'b0;
                        end
                    end
                end
                S_EVAL: begin
                    r_gap  <= since_pulse + TIME_W'(1);
                    r_emit <= emit;
                    if (emit) begin
                        r_burst <= r_time;
                    end
                    if (!full && stall_emit) begin
                        r_stall_rep <= 1'b1;
                    end
                end
                S_DIV: ;
                S_INS: r_fill <= r_fill + CNT_W'(1);
                S_PICK: begin
                    if (out_free) begin
                        r_fill <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sample interval on accept, result fields and pick position on evaluation, outputs on the pick.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_interval <= r_gap;
        end
        if (r_state == S_EVAL) begin
            r_out_stalled <= !full && stall_emit;
            r_out_cnt     <= fill_ext[COUNT_W-1:0];
            if (full) begin
                r_pick_zero <= 1'b0;
                r_pick_idx  <= M_C[IDX_W-1:0];
            end else if (stall_emit) begin
                r_pick_zero <= (zsum < {1'b0, N_C});
                r_pick_idx  <= zdiff[IDX_W-1:0];
            end else begin
                r_pick_zero <= (fill_n == '0);
                r_pick_idx  <= half[IDX_W-1:0];
            end
        end
        if (r_state == S_PICK && out_free) begin
            r_rpm     <= r_pick_zero ? '0 : links[r_pick_idx + IDX_W'(1)].value;
            r_stalled <= r_out_stalled;
            r_count   <= r_out_cnt;
        end
    end

    tbm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_interval (r_interval),
        .i_ppr      (r_ppr),
        .o_done     (div_done),
        .o_speed    (div_speed)
    );

    assign links[0].gt    = 1'b0;
    assign links[0].value = '0;

    for (genvar g = 0; g < BURST_LEN; g++) begin : g_cell
        assign occ[g] = (r_fill > CNT_W'(g));

        tbm_cell u_cell (
            .i_clk  (i_clk),
            .i_load (r_state == S_INS),
            .i_new  (div_speed),
            .i_occ  (occ[g]),
            .i_left (links[g]),
            .o_link (links[g+1])
        );

        if (g == 0) begin : g_first
            assign order_ok[g] = 1'b1;
        end else begin : g_rest
            assign order_ok[g] = !occ[g] || (links[g].value <= links[g+1].value);
        end
    end

    assign o_valid        = r_valid;
    assign o_rpm          = r_rpm;
    assign o_stalled      = r_stalled;
    assign o_sample_count = r_count;

    // The occupied cells always hold an ascending sequence.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&order_ok))
        else $error("sorter chain out of order");

    // The fill count never passes the burst length.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= N_C))
        else $error("burst fill overflow");

    // A stall report arms the repeat hold.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && !full && stall_emit) |=> r_stall_rep)
        else $error("stall hold not set after stall report");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_rpm)))
        else $error("pending result overwritten");

endmodule

/* hdl/tbm_cell.sv */
// One cell of the insertion sorting chain: holds one speed sample.
`timescale 1ns / 1ps

module tbm_cell
    import tbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [SPEED_W-1:0] i_new,
    input  logic               i_occ,
    input  t_link              i_left,
    output t_link              o_link
);

    logic [SPEED_W-1:0] r_val;
    logic               gt;

    // An empty cell counts as larger than any sample.
    assign gt = !i_occ || (r_val > i_new);

    always_ff @(posedge i_clk) begin
        if (i_load && gt) begin
            r_val <= i_left.gt ? i_left.value : i_new;
        end
    end

    assign o_link.gt    = gt;
    assign o_link.value = r_val;

endmodule

/* hdl/tbm_divider.sv */
// Speed computation: product, saturation checks and a bit-serial restoring divider.
`timescale 1ns / 1ps

module tbm_divider
    import tbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TIME_W-1:0]  i_interval,
    input  logic [PPR_W-1:0]   i_ppr,
    output logic               o_done,
    output logic [SPEED_W-1:0] o_speed
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_CHK  = 3'b010,
        D_RUN  = 3'b100
    } t_dstate;

    t_dstate             r_state;
    logic                r_done;
    logic [PROD_W-1:0]   r_prod;
    logic [NUM_W-1:0]    r_dvs;
    logic [NUM_W-1:0]    r_rem;
    logic [DCNT_W-1:0]   r_cnt;
    logic [SPEED_W-1:0]  r_q;

    logic [PPR_W-1:0]    ppr_eff;
    logic [NUM_W:0]      trial;
    logic [NUM_W:0]      diff;
    logic                qbit;

    assign ppr_eff = (i_ppr == '0) ? PPR_W'(1) : i_ppr;
    assign trial   = {r_rem, NUM_BITS[r_cnt]};
    assign diff    = trial - {1'b0, r_dvs};
    assign qbit    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    if (r_prod <= PROD_W'(SAT_LIMIT) || r_prod > PROD_W'(RPM_NUM)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == '0) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_prod <= PROD_W'(i_interval) * PROD_W'(ppr_eff);
                end
            end
            D_CHK: begin
                r_dvs <= r_prod[NUM_W-1:0];
                r_rem <= '0;
                r_cnt <= DCNT_W'(NUM_W - 1);
                if (r_prod <= PROD_W'(SAT_LIMIT)) begin
                    r_q <= '1;
                end else begin
                    r_q <= '0;
                end
            end
            D_RUN: begin
                if (qbit) begin
                    r_rem <= diff[NUM_W-1:0];
                end else begin
                    r_rem <= trial[NUM_W-1:0];
                end
                r_q   <= {r_q[SPEED_W-2:0], qbit};
                r_cnt <= r_cnt - DCNT_W'(1);
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_speed = r_q;

endmodule
